### rtl/barrier_passage_controller_top_defines.svh
// Assertion macros for the barrier passage controller.
`ifndef BARRIER_PASSAGE_CONTROLLER_TOP_DEFINES_SVH
`define BARRIER_PASSAGE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define BPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked during reset as well
`define BPC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define BPC_ASSERT(lbl, clk, rst, prop)
`define BPC_ASSERT_RST(lbl, clk, prop)
`endif

`endif

### rtl/bpc_pkg.sv
package bpc_pkg;

  localparam int CntW = 16;

  localparam logic [2:0] MODE_FORCED = 3'd0;
  localparam logic [2:0] MODE_IDLE   = 3'd1;
  localparam logic [2:0] MODE_AB     = 3'd2;
  localparam logic [2:0] MODE_BA     = 3'd3;
  localparam logic [2:0] MODE_HOLDAB = 3'd4;
  localparam logic [2:0] MODE_HOLDBA = 3'd5;

  // sensor latch bit positions
  localparam int LAT_AO = 0;
  localparam int LAT_AI = 1;
  localparam int LAT_BI = 2;
  localparam int LAT_BO = 3;

  localparam logic [1:0] CFG_PULSE_TICKS  = 2'd0;
  localparam logic [1:0] CFG_HOLD_TICKS   = 2'd1;
  localparam logic [1:0] CFG_SAFETY_TICKS = 2'd2;

  localparam logic [CntW-1:0] PULSE_TICKS_RST  = 16'd60;
  localparam logic [CntW-1:0] HOLD_TICKS_RST   = 16'd500;
  localparam logic [CntW-1:0] SAFETY_TICKS_RST = 16'd2000;

  typedef struct packed {
    logic det_a_outer;
    logic det_a_inner;
    logic det_b_inner;
    logic det_b_outer;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       alarm_on;
    logic       open_drive;
    logic       close_drive;
    logic       barrier_is_open;
    logic       barrier_moving;
  } out_t;

  typedef struct packed {
    logic [CntW-1:0] pulse_ticks;
    logic [CntW-1:0] hold_ticks;
    logic [CntW-1:0] safety_ticks;
  } cfg_t;

  // drive requests raised by the passage logic this tick
  typedef struct packed {
    logic open_set;
    logic close_set;
  } req_t;

  // actuator status after this tick
  typedef struct packed {
    logic open_drive;
    logic close_drive;
    logic is_open;
    logic moving;
  } act_t;

  function automatic logic [CntW-1:0] at_least_one(input logic [CntW-1:0] v);
    at_least_one = (v == '0) ? {{(CntW-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

### rtl/bpc_ctrl.sv
module bpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  bpc_pkg::in_t  det,
  input  bpc_pkg::cfg_t cfg,
  output bpc_pkg::req_t req,
  output logic [2:0]    mode_next,
  output logic          alarm_next
);
  import bpc_pkg::*;
  `include "barrier_passage_controller_top_defines.svh"

  logic [2:0]      mode;
  logic [3:0]      latches;
  logic [3:0]      latches_next;
  logic [1:0]      midpoint;
  logic [1:0]      midpoint_next;
  logic            alarm;
  logic [CntW-1:0] hold_count;
  logic [CntW-1:0] hold_count_next;
  logic [CntW-1:0] safety_count;
  logic [CntW-1:0] safety_count_next;
  logic [3:0]      det_vec;

  assign det_vec = {det.det_b_outer, det.det_b_inner, det.det_a_inner, det.det_a_outer};

  always_comb begin
    latches_next      = latches | det_vec;
    mode_next         = mode;
    alarm_next        = alarm;
    midpoint_next     = midpoint;
    hold_count_next   = hold_count;
    safety_count_next = safety_count;
    req               = '0;

    // safety timer, restarted by any detection
    if (det_vec != 4'd0) begin
      safety_count_next = at_least_one(cfg.safety_ticks);
    end else if (safety_count != '0) begin
      safety_count_next = safety_count - 1'b1;
      if (safety_count_next == '0) begin
        alarm_next = 1'b0;
        if (mode_next != MODE_IDLE) req.open_set = 1'b1;
        mode_next = MODE_IDLE;
      end
    end

    // hold timer runs on even after a safety expiry
    if (hold_count != '0) begin
      hold_count_next = hold_count - 1'b1;
      if (hold_count_next == '0) begin
        alarm_next   = 1'b0;
        req.open_set = 1'b1;
        mode_next    = MODE_IDLE;
      end
    end

    unique case (mode_next)
      MODE_FORCED: begin
        if (latches_next[LAT_BO]) begin
          mode_next = MODE_AB;
          midpoint_next[0] = 1'b1;
          latches_next[LAT_BO] = 1'b0;
        end else if (latches_next[LAT_AO]) begin
          mode_next = MODE_BA;
          midpoint_next[1] = 1'b1;
          latches_next[LAT_AO] = 1'b0;
        end
      end
      MODE_IDLE: begin
        if (latches_next[LAT_AO]) begin
          alarm_next = 1'b1;
          mode_next = MODE_AB;
          midpoint_next[0] = 1'b0;
          latches_next[LAT_AO] = 1'b0;
        end else if (latches_next[LAT_BO]) begin
          req.close_set = 1'b1;
          alarm_next = 1'b1;
          mode_next = MODE_BA;
          midpoint_next[1] = 1'b0;
          latches_next[LAT_BO] = 1'b0;
        end else if (latches_next[LAT_AI] || latches_next[LAT_BI]) begin
          req.close_set = 1'b1;
          alarm_next = 1'b1;
          mode_next = MODE_FORCED;
          latches_next[LAT_AI] = 1'b0;
          latches_next[LAT_BI] = 1'b0;
        end
      end
      MODE_AB: begin
        if (latches_next[LAT_AI]) begin
          req.close_set = 1'b1;
          latches_next[LAT_AI] = 1'b0;
        end
        if (latches_next[LAT_BI]) begin
          midpoint_next[0] = 1'b1;
          latches_next[LAT_BI] = 1'b0;
        end
        if (latches_next[LAT_BO] && midpoint_next[0]) begin
          alarm_next = 1'b0;
          hold_count_next = at_least_one(cfg.hold_ticks);
          mode_next = MODE_HOLDAB;
          latches_next[LAT_BO] = 1'b0;
        end
      end
      MODE_BA: begin
        if (latches_next[LAT_AI]) begin
          req.close_set = 1'b1;
          midpoint_next[1] = 1'b1;
          latches_next[LAT_AI] = 1'b0;
        end
        if (latches_next[LAT_AO] && midpoint_next[1]) begin
          alarm_next = 1'b0;
          hold_count_next = at_least_one(cfg.hold_ticks);
          mode_next = MODE_HOLDBA;
          latches_next[LAT_AO] = 1'b0;
        end
      end
      MODE_HOLDAB: begin
        if (latches_next[LAT_AO] || latches_next[LAT_AI]) begin
          hold_count_next = '0;
          mode_next = MODE_AB;
          midpoint_next[0] = 1'b0;
          latches_next[LAT_AO] = 1'b0;
          latches_next[LAT_AI] = 1'b0;
        end else if (latches_next[LAT_BO]) begin
          hold_count_next = '0;
          mode_next = MODE_BA;
          req.close_set = 1'b1;
          midpoint_next[1] = 1'b0;
          latches_next[LAT_BO] = 1'b0;
        end
      end
      MODE_HOLDBA: begin
        if (latches_next[LAT_BI] || latches_next[LAT_BO]) begin
          hold_count_next = '0;
          mode_next = MODE_BA;
          midpoint_next[1] = 1'b0;
          latches_next[LAT_BI] = 1'b0;
          latches_next[LAT_BO] = 1'b0;
        end else if (latches_next[LAT_AO]) begin
          hold_count_next = '0;
          mode_next = MODE_AB;
          req.close_set = 1'b1;
          midpoint_next[0] = 1'b0;
          latches_next[LAT_AO] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      latches      <= '0;
      midpoint     <= '0;
      alarm        <= 1'b0;
      hold_count   <= '0;
      safety_count <= '0;
    end else if (step) begin
      mode         <= mode_next;
      latches      <= latches_next;
      midpoint     <= midpoint_next;
      alarm        <= alarm_next;
      hold_count   <= hold_count_next;
      safety_count <= safety_count_next;
    end
  end

  `BPC_ASSERT(a_safety_restart, clk, rst, step && (det_vec != 4'd0) |=> safety_count != '0)
  `BPC_ASSERT(a_hold_only_on_step, clk, rst, !step |=> $stable(hold_count) && $stable(mode))

endmodule

### rtl/bpc_actuator.sv
module bpc_actuator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  bpc_pkg::req_t              req,
  input  logic [bpc_pkg::CntW-1:0]   pulse_ticks,
  output bpc_pkg::act_t              act
);
  import bpc_pkg::*;
  `include "barrier_passage_controller_top_defines.svh"

  logic            open_req;
  logic            open_req_next;
  logic            close_req;
  logic            close_req_next;
  logic [CntW-1:0] pulse_count;
  logic [CntW-1:0] pulse_count_next;
  logic            dir_open;
  logic            dir_open_next;
  logic            open_flag;
  logic            open_flag_next;

  always_comb begin
    open_req_next    = open_req | req.open_set;
    close_req_next   = close_req | req.close_set;
    pulse_count_next = pulse_count;
    dir_open_next    = dir_open;
    open_flag_next   = open_flag;

    if (pulse_count != '0) begin
      pulse_count_next = pulse_count - 1'b1;
      if (pulse_count_next == '0) open_flag_next = dir_open;
    end
    // close is served before open
    if (pulse_count_next == '0) begin
      if (close_req_next) begin
        close_req_next   = 1'b0;
        dir_open_next    = 1'b0;
        pulse_count_next = at_least_one(pulse_ticks);
      end else if (open_req_next) begin
        open_req_next    = 1'b0;
        dir_open_next    = 1'b1;
        pulse_count_next = at_least_one(pulse_ticks);
      end
    end

    act.moving      = (pulse_count_next != '0);
    act.open_drive  = act.moving && dir_open_next;
    act.close_drive = act.moving && !dir_open_next;
    act.is_open     = open_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_req    <= 1'b0;
      close_req   <= 1'b0;
      pulse_count <= '0;
      dir_open    <= 1'b0;
      open_flag   <= 1'b1;
    end else if (step) begin
      open_req    <= open_req_next;
      close_req   <= close_req_next;
      pulse_count <= pulse_count_next;
      dir_open    <= dir_open_next;
      open_flag   <= open_flag_next;
    end
  end

  `BPC_ASSERT(a_pulse_frozen, clk, rst, !step |=> $stable(pulse_count) && $stable(dir_open))

endmodule

### rtl/barrier_passage_controller_top.sv
// Path: the input register takes each tick on its transfer, the result register its result on a step.
// Throughput: one tick item per cycle; while a result waits, one more transfer lands in the
// input register and the input side then stalls until the result is taken.
// The whole tick update is combinational next-state logic between the two registers.
// Reset (rst, synchronous, active high): idle mode, latches and timers cleared, barrier
// flagged open, no drive pulse, configuration back to 60 / 500 / 2000 ticks.
module barrier_passage_controller_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bpc_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bpc_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bpc_pkg::CntW-1:0]   cfg_data
);
  import bpc_pkg::*;
  `include "barrier_passage_controller_top_defines.svh"

  cfg_t       cfg;
  logic       in_reg_valid;
  in_t        in_reg;
  logic       step;
  req_t       req;
  act_t       act;
  logic [2:0] mode_next;
  logic       alarm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks  <= PULSE_TICKS_RST;
      cfg.hold_ticks   <= HOLD_TICKS_RST;
      cfg.safety_ticks <= SAFETY_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_TICKS:  cfg.pulse_ticks  <= cfg_data;
        CFG_HOLD_TICKS:   cfg.hold_ticks   <= cfg_data;
        CFG_SAFETY_TICKS: cfg.safety_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // tick advances when the input register holds a tick and the result register is free or being drained
  assign step     = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= in_data;
  end

  bpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .det        (in_reg),
    .cfg        (cfg),
    .req        (req),
    .mode_next  (mode_next),
    .alarm_next (alarm_next)
  );

  bpc_actuator u_act (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .req         (req),
    .pulse_ticks (cfg.pulse_ticks),
    .act         (act)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.mode            <= mode_next;
      out_data.alarm_on        <= alarm_next;
      out_data.open_drive      <= act.open_drive;
      out_data.close_drive     <= act.close_drive;
      out_data.barrier_is_open <= act.is_open;
      out_data.barrier_moving  <= act.moving;
    end
  end

  `BPC_ASSERT_RST(a_reset_empties, clk, rst |=> !out_valid && !in_reg_valid)
  `BPC_ASSERT(a_one_drive, clk, rst, out_valid |-> !(out_data.open_drive && out_data.close_drive))
  `BPC_ASSERT(a_moving_match, clk, rst,
    out_valid |-> out_data.barrier_moving == (out_data.open_drive || out_data.close_drive))

endmodule

### dv/barrier_passage_controller_top_tb.sv
module barrier_passage_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  localparam logic [3:0] S_NONE = 4'b0000;
  localparam logic [3:0] S_AO   = 4'b0001 << LAT_AO;
  localparam logic [3:0] S_AI   = 4'b0001 << LAT_AI;
  localparam logic [3:0] S_BI   = 4'b0001 << LAT_BI;
  localparam logic [3:0] S_BO   = 4'b0001 << LAT_BO;

  localparam int RESULT_SETTLE = 8;
  localparam int LONG_STALL    = 200;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_style_e;

  logic            clk;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_t             in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = CFG_PULSE_TICKS;
  logic [CntW-1:0] cfg_data  = '0;

  // predictor state, mirrors the block after reset
  logic [2:0]      p_mode       = MODE_IDLE;
  logic [3:0]      p_lat        = '0;
  logic [1:0]      p_mid        = '0;
  logic            p_open_req   = 1'b0;
  logic            p_close_req  = 1'b0;
  logic            p_alarm      = 1'b0;
  logic [CntW-1:0] p_pulse      = '0;
  logic            p_dir_open   = 1'b0;
  logic            p_open_flag  = 1'b1;
  logic [CntW-1:0] p_hold       = '0;
  logic [CntW-1:0] p_safety     = '0;
  logic [CntW-1:0] c_pulse      = PULSE_TICKS_RST;
  logic [CntW-1:0] c_hold       = HOLD_TICKS_RST;
  logic [CntW-1:0] c_safety     = SAFETY_TICKS_RST;

  in_t  pending_ticks[$];
  out_t expected_status_q[$];

  int n_queued      = 0;
  int n_ticks       = 0;
  int n_checked     = 0;
  int n_errors      = 0;
  int n_settings    = 0;
  int n_passages    = 0;
  int n_long_stalls = 0;
  int gap_left      = 0;
  int burst_left    = 0;
  int rx_count      = 0;
  int rx_hold_off   = 0;
  int rx_style_left = 0;
  int rx_phase      = 0;
  rx_style_e rx_style = RX_STEADY;

  barrier_passage_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CntW-1:0] min_one(input logic [CntW-1:0] v);
    return (v == '0) ? CntW'(1) : v;
  endfunction

  // one tick of the controller: latches, timers, passage FSM, actuator
  function automatic out_t advance_tick(input in_t t);
    logic [3:0] det;
    out_t r;
    det = '0;
    det[LAT_AO] = t.det_a_outer;
    det[LAT_AI] = t.det_a_inner;
    det[LAT_BI] = t.det_b_inner;
    det[LAT_BO] = t.det_b_outer;
    p_lat = p_lat | det;

    if (det != '0) begin
      p_safety = min_one(c_safety);
    end else if (p_safety != '0) begin
      p_safety = p_safety - 1'b1;
      if (p_safety == '0) begin
        p_alarm = 1'b0;
        if (p_mode != MODE_IDLE) p_open_req = 1'b1;
        p_mode = MODE_IDLE;
      end
    end

    if (p_hold != '0) begin
      p_hold = p_hold - 1'b1;
      if (p_hold == '0) begin
        p_alarm = 1'b0;
        p_open_req = 1'b1;
        p_mode = MODE_IDLE;
      end
    end

    case (p_mode)
      MODE_FORCED: begin
        if (p_lat[LAT_BO]) begin
          p_mode = MODE_AB; p_mid[0] = 1'b1; p_lat[LAT_BO] = 1'b0;
        end else if (p_lat[LAT_AO]) begin
          p_mode = MODE_BA; p_mid[1] = 1'b1; p_lat[LAT_AO] = 1'b0;
        end
      end
      MODE_IDLE: begin
        if (p_lat[LAT_AO]) begin
          p_alarm = 1'b1; p_mode = MODE_AB; p_mid[0] = 1'b0; p_lat[LAT_AO] = 1'b0;
        end else if (p_lat[LAT_BO]) begin
          p_close_req = 1'b1; p_alarm = 1'b1; p_mode = MODE_BA;
          p_mid[1] = 1'b0; p_lat[LAT_BO] = 1'b0;
        end else if (p_lat[LAT_AI] || p_lat[LAT_BI]) begin
          p_close_req = 1'b1; p_alarm = 1'b1; p_mode = MODE_FORCED;
          p_lat[LAT_AI] = 1'b0; p_lat[LAT_BI] = 1'b0;
        end
      end
      MODE_AB: begin
        if (p_lat[LAT_AI]) begin
          p_close_req = 1'b1; p_lat[LAT_AI] = 1'b0;
        end
        if (p_lat[LAT_BI]) begin
          p_mid[0] = 1'b1; p_lat[LAT_BI] = 1'b0;
        end
        if (p_lat[LAT_BO] && p_mid[0]) begin
          p_alarm = 1'b0; p_hold = min_one(c_hold); p_mode = MODE_HOLDAB;
          p_lat[LAT_BO] = 1'b0;
        end
      end
      MODE_BA: begin
        if (p_lat[LAT_AI]) begin
          p_close_req = 1'b1; p_mid[1] = 1'b1; p_lat[LAT_AI] = 1'b0;
        end
        if (p_lat[LAT_AO] && p_mid[1]) begin
          p_alarm = 1'b0; p_hold = min_one(c_hold); p_mode = MODE_HOLDBA;
          p_lat[LAT_AO] = 1'b0;
        end
      end
      MODE_HOLDAB: begin
        if (p_lat[LAT_AO] || p_lat[LAT_AI]) begin
          p_hold = '0; p_mode = MODE_AB; p_mid[0] = 1'b0;
          p_lat[LAT_AO] = 1'b0; p_lat[LAT_AI] = 1'b0;
        end else if (p_lat[LAT_BO]) begin
          p_hold = '0; p_mode = MODE_BA; p_close_req = 1'b1;
          p_mid[1] = 1'b0; p_lat[LAT_BO] = 1'b0;
        end
      end
      MODE_HOLDBA: begin
        if (p_lat[LAT_BI] || p_lat[LAT_BO]) begin
          p_hold = '0; p_mode = MODE_BA; p_mid[1] = 1'b0;
          p_lat[LAT_BI] = 1'b0; p_lat[LAT_BO] = 1'b0;
        end else if (p_lat[LAT_AO]) begin
          p_hold = '0; p_mode = MODE_AB; p_close_req = 1'b1;
          p_mid[0] = 1'b0; p_lat[LAT_AO] = 1'b0;
        end
      end
      default: ;
    endcase

    // a pulse ending this tick frees the actuator for a new request at once
    if (p_pulse != '0) begin
      p_pulse = p_pulse - 1'b1;
      if (p_pulse == '0) p_open_flag = p_dir_open;
    end
    if (p_pulse == '0) begin
      if (p_close_req) begin
        p_close_req = 1'b0; p_dir_open = 1'b0; p_pulse = min_one(c_pulse);
      end else if (p_open_req) begin
        p_open_req = 1'b0; p_dir_open = 1'b1; p_pulse = min_one(c_pulse);
      end
    end

    r.mode            = p_mode;
    r.alarm_on        = p_alarm;
    r.open_drive      = (p_pulse != '0) && p_dir_open;
    r.close_drive     = (p_pulse != '0) && !p_dir_open;
    r.barrier_is_open = p_open_flag;
    r.barrier_moving  = (p_pulse != '0);
    return r;
  endfunction

  function automatic int rand_gap();
    int lim;
    lim = int'(c_safety) + 2;
    if (lim > 30) lim = 30;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, lim);
    return $urandom_range(0, 3);
  endfunction

  task automatic queue_tick(input logic [3:0] s);
    in_t t;
    t.det_a_outer = s[LAT_AO];
    t.det_a_inner = s[LAT_AI];
    t.det_b_inner = s[LAT_BI];
    t.det_b_outer = s[LAT_BO];
    pending_ticks.push_back(t);
    n_queued++;
  endtask

  task automatic queue_idle(input int n);
    repeat (n) queue_tick(S_NONE);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CntW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_PULSE_TICKS:  c_pulse  = val;
      CFG_HOLD_TICKS:   c_hold   = val;
      CFG_SAFETY_TICKS: c_safety = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CntW-1:0] pulse, input logic [CntW-1:0] hold,
                            input logic [CntW-1:0] safety);
    write_reg(CFG_PULSE_TICKS, pulse);
    write_reg(CFG_HOLD_TICKS, hold);
    write_reg(CFG_SAFETY_TICKS, safety);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // nothing queued, nothing on the wire, nothing outstanding
  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_status_q.size() != 0);
    repeat (RESULT_SETTLE) @(posedge clk);
  endtask

  task automatic queue_random_traffic(input int n_items);
    int target;
    int pick;
    logic [3:0] exit_s;
    target = n_queued + n_items;
    @(negedge clk);
    while (n_queued < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        n_passages++;
        if (pick[0]) begin
          queue_tick(S_AO);
          queue_idle(rand_gap());
          if ($urandom_range(0, 2) == 0) begin
            queue_tick(S_AI);
            queue_idle(rand_gap());
          end
          queue_tick(S_BI);
          queue_idle(rand_gap());
          queue_tick(S_BO);
        end else begin
          queue_tick(S_BO);
          queue_idle(rand_gap());
          queue_tick(S_AI);
          queue_idle(rand_gap());
          queue_tick(S_AO);
        end
        queue_idle(rand_gap());
      end else if (pick < 8) begin
        // abandoned crossing, left to the safety timer
        queue_tick($urandom_range(0, 1) ? S_AO : S_BO);
        queue_idle(rand_gap());
        if ($urandom_range(0, 1)) queue_tick($urandom_range(0, 1) ? S_AI : S_BI);
        queue_idle($urandom_range(0, 35));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) queue_tick(4'($urandom_range(0, 15)));
      end else begin
        // inner sensor first: forced validation, then out either side
        queue_tick($urandom_range(0, 1) ? S_AI : S_BI);
        queue_idle(rand_gap());
        exit_s = $urandom_range(0, 1) ? S_BO : S_AO;
        queue_tick(exit_s);
        queue_idle(rand_gap());
        queue_tick(exit_s);
        queue_idle(rand_gap());
      end
    end
  endtask

  always @(posedge clk) begin : drive_ticks
    if (rst) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_status_q.push_back(advance_tick(in_data));
        n_ticks++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_data  <= pending_ticks.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : accept_status
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_count++;
      rx_phase++;
      if (rx_hold_off > 0) begin
        rx_hold_off--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && (rx_count == 150 || rx_count == 380)) begin
        // long hold-off so the input side backs up
        rx_hold_off = LONG_STALL;
        n_long_stalls++;
        out_ready <= 1'b0;
      end else begin
        if (rx_style_left == 0) begin
          rx_style      = rx_style_e'($urandom_range(0, 2));
          rx_style_left = $urandom_range(8, 64);
        end else begin
          rx_style_left--;
        end
        case (rx_style)
          RX_STEADY: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= (rx_phase % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_status
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        $error("status transfer with nothing expected: %p", out_data);
        n_errors++;
      end else begin
        want = expected_status_q.pop_front();
        n_checked++;
        if (out_data.mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, out_data.mode);
          n_errors++;
        end
        if (out_data.alarm_on !== want.alarm_on) begin
          $error("alarm_on: expected %0b, got %0b", want.alarm_on, out_data.alarm_on);
          n_errors++;
        end
        if (out_data.open_drive !== want.open_drive) begin
          $error("open_drive: expected %0b, got %0b", want.open_drive, out_data.open_drive);
          n_errors++;
        end
        if (out_data.close_drive !== want.close_drive) begin
          $error("close_drive: expected %0b, got %0b", want.close_drive,
                 out_data.close_drive);
          n_errors++;
        end
        if (out_data.barrier_is_open !== want.barrier_is_open) begin
          $error("barrier_is_open: expected %0b, got %0b", want.barrier_is_open,
                 out_data.barrier_is_open);
          n_errors++;
        end
        if (out_data.barrier_moving !== want.barrier_moving) begin
          $error("barrier_moving: expected %0b, got %0b", want.barrier_moving,
                 out_data.barrier_moving);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // index past the last register must be ignored
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    set_timing(16'd2, 16'd3, 16'd6);

    @(negedge clk);
    queue_tick(S_NONE);
    // A to B with a stray A inner, hold runs out
    queue_tick(S_AO);
    queue_tick(S_AI);
    queue_tick(S_BI);
    queue_tick(S_BO);
    queue_idle(3);
    // B to A, then re-entry from B side during hold
    queue_tick(S_BO);
    queue_tick(S_AI);
    queue_tick(S_AO);
    queue_tick(S_BI);
    queue_tick(S_AI);
    queue_tick(S_AO);
    // reversal from hold, then safety expiry mid-crossing
    queue_tick(S_AO);
    queue_tick(S_AI);
    queue_idle(6);
    // forced validation out through B
    queue_tick(S_BI);
    queue_tick(S_BO);
    // all four together, A outer stays latched into the hold
    queue_tick(S_AO | S_AI | S_BI | S_BO);
    queue_tick(S_NONE);
    queue_tick(S_AI);
    queue_tick(S_BI);
    queue_tick(S_BO);
    queue_tick(S_BO);
    drain();

    set_timing(PULSE_TICKS_RST, HOLD_TICKS_RST, SAFETY_TICKS_RST);
    queue_random_traffic(60);
    drain();
    set_timing(16'd1, 16'd1, 16'd1);
    queue_random_traffic(60);
    drain();
    // zero counts as one tick
    set_timing(16'd0, 16'd0, 16'd0);
    queue_random_traffic(60);
    drain();
    repeat (4) begin
      set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 15)),
                 16'($urandom_range(2, 25)));
      queue_random_traffic(60);
      drain();
    end
    // maximum last: a full-length pulse would stall later phases
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random_traffic(40);
    drain();

    $display("Checked %0d status results from %0d ticks under %0d register settings.",
             n_checked, n_ticks, n_settings);
    $display("%0d passages queued; output held off for %0d long stretches.",
             n_passages, n_long_stalls);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### barrier_passage_controller_top.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_ctrl.sv
rtl/bpc_actuator.sv
rtl/barrier_passage_controller_top.sv
dv/barrier_passage_controller_top_tb.sv
